// ===== hw/rtl/sha1md_pkg.sv =====
package sha1md_pkg;

	// Queue between the front and the back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One classified request as handed from the front to the back
	typedef struct packed {
		logic [31:0] word;      // message word, already masked and padded when a short last word
		logic [5:0]  add_bits;  // message bits carried by this word
		logic        is_last;   // final word of the message
		logic        is_full;   // final word carries four bytes, 0x80 word still owed
	} sha1md_entry_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_DONE
	} sha1md_state_t;

	// Back-end status, watched by the top level
	typedef struct packed {
		sha1md_state_t state;
		logic [3:0]    pos;
		logic          bits_zero;
	} sha1md_status_t;

endpackage

// ===== hw/rtl/sha1md_front.sv =====
module sha1md_front import sha1md_pkg::*; (
	input  logic          msg_valid,
	output logic          msg_stall,
	input  logic [31:0]   data_word,
	input  logic [2:0]    byte_count,
	input  logic          last,
	input  logic          q_full,
	output logic          q_push,
	output sha1md_entry_t q_entry
);

	logic [2:0] cnt;

	// Hold the sender off while the queue is full
	assign msg_stall = q_full;
	assign q_push    = msg_valid && !q_full;

	// Clamp the byte count to a whole word
	assign cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;

	// Classify the request: plain word, full last word or padded last word
	always_comb begin
		q_entry.is_last  = last;
		q_entry.is_full  = 1'b0;
		q_entry.add_bits = 6'd32;
		q_entry.word     = data_word;
		if (last) begin
			q_entry.add_bits = {cnt, 3'b000};
			case (cnt)
				3'd0:    q_entry.word = 32'h8000_0000;
				3'd1:    q_entry.word = {data_word[31:24], 8'h80, 16'h0000};
				3'd2:    q_entry.word = {data_word[31:16], 8'h80, 8'h00};
				3'd3:    q_entry.word = {data_word[31:8], 8'h80};
				default: begin
					q_entry.word    = data_word;
					q_entry.is_full = 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/sha1md_queue.sv =====
module sha1md_queue import sha1md_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sha1md_entry_t push_entry,
	output logic          full,
	input  logic          pop,
	output logic          nempty,
	output sha1md_entry_t head
);

	sha1md_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]      wr_q;
	logic [QPTR_W-1:0]      rd_q;
	logic [QPTR_W:0]        cnt_q;

	assign full   = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rd_q];

	// Store the request at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/sha1md_back.sv =====
module sha1md_back import sha1md_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nempty,
	input  sha1md_entry_t  q_head,
	output logic           q_pop,
	output logic           digest_valid,
	input  logic           digest_stall,
	output logic [31:0]    digest_word0,
	output logic [31:0]    digest_word1,
	output logic [31:0]    digest_word2,
	output logic [31:0]    digest_word3,
	output logic [31:0]    digest_word4,
	output sha1md_status_t status
);

	localparam logic [31:0] IV0 = 32'h6745_2301;
	localparam logic [31:0] IV1 = 32'hefcd_ab89;
	localparam logic [31:0] IV2 = 32'h98ba_dcfe;
	localparam logic [31:0] IV3 = 32'h1032_5476;
	localparam logic [31:0] IV4 = 32'hc3d2_e1f0;
	localparam logic [31:0] K0  = 32'h5a82_7999;
	localparam logic [31:0] K1  = 32'h6ed9_eba1;
	localparam logic [31:0] K2  = 32'h8f1b_bcdc;
	localparam logic [31:0] K3  = 32'hca62_c1d6;
	localparam logic [31:0] PAD_WORD = 32'h8000_0000;
	localparam int          ROUNDS   = 80;
	localparam logic [6:0]  RND_LAST = 7'(ROUNDS - 1);
	localparam logic [6:0]  RND_P1   = 7'd20;
	localparam logic [6:0]  RND_P2   = 7'd40;
	localparam logic [6:0]  RND_P3   = 7'd60;

	sha1md_state_t state_q, state_d;
	logic [31:0]   w_q [16];
	logic [31:0]   h_q [5];
	logic [31:0]   v_q [5];
	logic [3:0]    pos_q;
	logic [63:0]   bits_q;
	logic [6:0]    rnd_q;
	logic          pad_q;
	logic          need80_q;
	logic          hi_done_q;
	logic          final_q;
	logic          out_valid_q;
	logic [31:0]   dig_q [5];

	logic          push;
	logic [31:0]   push_w;
	logic          wrap;
	logic          out_load;
	logic [31:0]   f;
	logic [31:0]   k;
	logic [31:0]   t;
	logic [31:0]   w_new;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_nempty) begin
					if (wrap) begin
						state_d = ST_ROUND;
					end else if (q_head.is_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (wrap) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == RND_LAST) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (final_q) begin
					state_d = ST_DONE;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: which word enters the block, when to pop and unload
	always_comb begin
		q_pop    = 1'b0;
		push     = 1'b0;
		push_w   = '0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop  = q_nempty;
				push   = q_nempty;
				push_w = q_head.word;
			end
			ST_PAD: begin
				push = 1'b1;
				if (need80_q) begin
					push_w = PAD_WORD;
				end else if (pos_q == 4'd14) begin
					push_w = bits_q[63:32];
				end else if (pos_q == 4'd15 && hi_done_q) begin
					push_w = bits_q[31:0];
				end else begin
					push_w = '0;
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || !digest_stall;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign wrap = push && (pos_q == 4'd15);

	// Round function and constant
	always_comb begin
		if (rnd_q < RND_P1) begin
			f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k = K0;
		end else if (rnd_q < RND_P2) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K1;
		end else if (rnd_q < RND_P3) begin
			f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k = K2;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K3;
		end
	end

	assign t     = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + w_q[0];
	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

	// Shift words in while filling, roll the schedule window while rounding
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= push_w;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	// Load and update the working variables
	always_ff @(posedge clk) begin
		if (wrap) begin
			for (int i = 0; i < 5; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			v_q[0] <= t;
			v_q[1] <= v_q[0];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
	end

	// Hold the digest for the receiver
	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= h_q[i];
			end
		end
	end

	// Control state, chaining value and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q[0]      <= IV0;
			h_q[1]      <= IV1;
			h_q[2]      <= IV2;
			h_q[3]      <= IV3;
			h_q[4]      <= IV4;
			pos_q       <= '0;
			bits_q      <= '0;
			rnd_q       <= '0;
			pad_q       <= 1'b0;
			need80_q    <= 1'b0;
			hi_done_q   <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				pos_q <= pos_q + 1'b1;
			end
			if (wrap) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (q_pop) begin
				bits_q <= bits_q + {58'd0, q_head.add_bits};
				if (q_head.is_last) begin
					pad_q    <= 1'b1;
					need80_q <= q_head.is_full;
				end
			end
			if (state_q == ST_PAD) begin
				if (need80_q) begin
					need80_q <= 1'b0;
				end else if (pos_q == 4'd14) begin
					hi_done_q <= 1'b1;
				end else if (pos_q == 4'd15 && hi_done_q) begin
					final_q <= 1'b1;
				end
			end
			if (state_q == ST_FINAL) begin
				for (int i = 0; i < 5; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			// drop the finished message and start afresh
			if (out_load) begin
				h_q[0]    <= IV0;
				h_q[1]    <= IV1;
				h_q[2]    <= IV2;
				h_q[3]    <= IV3;
				h_q[4]    <= IV4;
				pos_q     <= '0;
				bits_q    <= '0;
				pad_q     <= 1'b0;
				hi_done_q <= 1'b0;
				final_q   <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!digest_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign digest_valid     = out_valid_q;
	assign digest_word0     = dig_q[0];
	assign digest_word1     = dig_q[1];
	assign digest_word2     = dig_q[2];
	assign digest_word3     = dig_q[3];
	assign digest_word4     = dig_q[4];
	assign status.state     = state_q;
	assign status.pos       = pos_q;
	assign status.bits_zero = (bits_q == '0);

endmodule

// ===== hw/rtl/sha1_message_digest.sv =====
// SHA-1 message digest.
// Message channel (msg_valid / msg_stall): one big-endian 32-bit word per
// request, byte_count valid leading bytes, last marking the final word. Only
// a last word may carry fewer than four bytes; a count above four counts as four.
// Digest channel (digest_valid / digest_stall): one request per message with
// the five 32-bit words h0..h4 of the final chaining value.
// Words pass through a four-entry queue into the compression engine, which
// buffers 16 words and then runs one round per cycle through the 80 rounds,
// followed by the chaining update; no words leave the queue meanwhile. After
// the last word the engine inserts the remaining padding and length words, with
// one more block when they spill over; after the final chaining update it
// enters the done state and registers the digest once the output is free.
// Reset clears the queue, the chaining value to the initial hash, the word
// position and the bit length; no clearing pass is needed.
// While digest_stall is high the digest is held and the engine waits before
// starting the next message; words still enter until the queue is full, and
// then msg_stall rises.
module sha1_message_digest import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word0,
	output logic [31:0] digest_word1,
	output logic [31:0] digest_word2,
	output logic [31:0] digest_word3,
	output logic [31:0] digest_word4
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_nempty;
	sha1md_entry_t  q_in;
	sha1md_entry_t  q_head;
	sha1md_status_t status;

	sha1md_front u_front (
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_in)
	);

	sha1md_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.nempty     (q_nempty),
		.head       (q_head)
	);

	sha1md_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nempty     (q_nempty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word0 (digest_word0),
		.digest_word1 (digest_word1),
		.digest_word2 (digest_word2),
		.digest_word3 (digest_word3),
		.digest_word4 (digest_word4),
		.status       (status)
	);

	// An accepted word is waiting in the queue on the next cycle
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall) |=> q_nempty)
		else $error("accepted word missing from queue");

	// A new digest only follows the done state
	a_digest_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> $past(status.state == ST_DONE))
		else $error("digest raised outside done state");

	// A new digest leaves the engine re-initialised
	a_digest_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> (status.pos == 4'd0 && status.bits_zero))
		else $error("engine not re-initialised after digest");

	// Rounds only begin on a full block
	a_round_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		(status.state == ST_ROUND && $past(status.state) != ST_ROUND)
		|-> status.pos == 4'd0)
		else $error("rounds started on a partial block");

endmodule
